@@ rtl/core/integer_stack_machine_assert.svh @@
// Assertion macros shared by the stack machine RTL.
`ifndef INTEGER_STACK_MACHINE_ASSERT_SVH
`define INTEGER_STACK_MACHINE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ISM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stack machine check failed");

// Next-cycle implication, checked out of reset.
`define ISM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stack machine check failed");

`endif

@@ rtl/core/ism_pkg.sv @@
package ism_pkg;

    // Command codes
    localparam logic [5:0] CMD_HALT       = 6'd0;
    localparam logic [5:0] CMD_IF         = 6'd1;
    localparam logic [5:0] CMD_PUSH_IMM   = 6'd2;
    localparam logic [5:0] CMD_PUSH_LOCAL = 6'd3;
    localparam logic [5:0] CMD_INC        = 6'd4;
    localparam logic [5:0] CMD_PUSH_INC   = 6'd5;
    localparam logic [5:0] CMD_DEC        = 6'd6;
    localparam logic [5:0] CMD_PUSH_DEC   = 6'd7;
    localparam logic [5:0] CMD_POP        = 6'd8;
    localparam logic [5:0] CMD_STACK_BASE = 6'd9;
    localparam logic [5:0] CMD_IMM_BASE   = 6'd25;
    localparam logic [5:0] CMD_LOCAL_BASE = 6'd41;
    localparam logic [5:0] CMD_LAST       = 6'd56;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DIV0  = 3'd1,
        ST_MOD0  = 3'd2,
        ST_OVER  = 3'd3,
        ST_UNDER = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        OP_AND = 4'd0, OP_OR  = 4'd1, OP_XOR = 4'd2, OP_ADD = 4'd3,
        OP_SUB = 4'd4, OP_MUL = 4'd5, OP_DIV = 4'd6, OP_MOD = 4'd7,
        OP_SHL = 4'd8, OP_SHR = 4'd9, OP_NE  = 4'd10, OP_LT = 4'd11,
        OP_LE  = 4'd12, OP_EQ = 4'd13, OP_GE = 4'd14, OP_GT = 4'd15
    } t_alu_op;

    typedef enum logic [3:0] {
        G_HALT, G_IF, G_PUSH_IMM, G_PUSH_LOCAL, G_INC, G_PUSH_INC, G_DEC,
        G_PUSH_DEC, G_POP, G_STACK_OP, G_IMM_OP, G_LOCAL_OP, G_NOP
    } t_group;

    typedef enum logic [2:0] {
        S_IDLE, S_RD1, S_RD2, S_EXEC, S_ALU, S_FIN, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        A_IDLE, A_DIV, A_FIX, A_DONE
    } t_alu_state;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } t_alu_rsp;

    // Command to instruction group
    function automatic t_group decode(input logic [5:0] cmd);
        t_group g;
        g = G_NOP;
        case (cmd)
            CMD_HALT:       g = G_HALT;
            CMD_IF:         g = G_IF;
            CMD_PUSH_IMM:   g = G_PUSH_IMM;
            CMD_PUSH_LOCAL: g = G_PUSH_LOCAL;
            CMD_INC:        g = G_INC;
            CMD_PUSH_INC:   g = G_PUSH_INC;
            CMD_DEC:        g = G_DEC;
            CMD_PUSH_DEC:   g = G_PUSH_DEC;
            CMD_POP:        g = G_POP;
            default: begin
                if (cmd > CMD_LAST)             g = G_NOP;
                else if (cmd >= CMD_LOCAL_BASE) g = G_LOCAL_OP;
                else if (cmd >= CMD_IMM_BASE)   g = G_IMM_OP;
                else                            g = G_STACK_OP;
            end
        endcase
        return g;
    endfunction

    // Operation within a group of sixteen
    function automatic t_alu_op op_of(input logic [5:0] cmd);
        logic [5:0] d;
        d = cmd - CMD_STACK_BASE;
        return t_alu_op'(d[3:0]);
    endfunction

endpackage

@@ rtl/core/ism_ram.sv @@
module ism_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/core/ism_alu.sv @@
module ism_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ism_pkg::t_alu_req i_req,
    input  logic [31:0]       i_a,
    input  logic [31:0]       i_b,
    output ism_pkg::t_alu_rsp o_rsp
);

    ism_pkg::t_alu_state r_state, n_state;
    logic [31:0] r_res, n_res;
    logic [32:0] r_rem;
    logic [31:0] r_quo, r_dv;
    logic [4:0]  r_cnt;
    logic        r_neg_q, r_neg_r, r_is_mod;

    logic [31:0] w_simple, w_abs_a, w_abs_b;
    logic [32:0] w_rem_sh, w_diff;
    logic        w_is_div;

    // Combinational operations (all but divide and modulo)
    always_comb begin
        case (i_req.op)
            ism_pkg::OP_AND: w_simple = i_a & i_b;
            ism_pkg::OP_OR:  w_simple = i_a | i_b;
            ism_pkg::OP_XOR: w_simple = i_a ^ i_b;
            ism_pkg::OP_ADD: w_simple = i_a + i_b;
            ism_pkg::OP_SUB: w_simple = i_a - i_b;
            ism_pkg::OP_MUL: w_simple = i_a * i_b;
            ism_pkg::OP_SHL: w_simple = i_a << i_b[4:0];
            ism_pkg::OP_SHR: w_simple = 32'($signed(i_a) >>> i_b[4:0]);
            ism_pkg::OP_NE:  w_simple = {31'd0, $signed(i_a) != $signed(i_b)};
            ism_pkg::OP_LT:  w_simple = {31'd0, $signed(i_a) <  $signed(i_b)};
            ism_pkg::OP_LE:  w_simple = {31'd0, $signed(i_a) <= $signed(i_b)};
            ism_pkg::OP_EQ:  w_simple = {31'd0, $signed(i_a) == $signed(i_b)};
            ism_pkg::OP_GE:  w_simple = {31'd0, $signed(i_a) >= $signed(i_b)};
            ism_pkg::OP_GT:  w_simple = {31'd0, $signed(i_a) >  $signed(i_b)};
            default:         w_simple = 32'd0;
        endcase
    end

    assign w_is_div = (i_req.op == ism_pkg::OP_DIV) || (i_req.op == ism_pkg::OP_MOD);
    assign w_abs_a  = i_a[31] ? (32'd0 - i_a) : i_a;
    assign w_abs_b  = i_b[31] ? (32'd0 - i_b) : i_b;

    // Restoring divide step, one quotient bit per cycle
    assign w_rem_sh = {r_rem[31:0], r_quo[31]};
    assign w_diff   = w_rem_sh - {1'b0, r_dv};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ism_pkg::A_IDLE: begin
                if (i_req.start) n_state = w_is_div ? ism_pkg::A_DIV : ism_pkg::A_DONE;
            end
            ism_pkg::A_DIV: begin
                if (r_cnt == 5'd0) n_state = ism_pkg::A_FIX;
            end
            ism_pkg::A_FIX:  n_state = ism_pkg::A_DONE;
            ism_pkg::A_DONE: n_state = ism_pkg::A_IDLE;
            default:         n_state = ism_pkg::A_IDLE;
        endcase
    end

    // Result register update
    always_comb begin
        n_res = r_res;
        case (r_state)
            ism_pkg::A_IDLE: n_res = w_simple;
            ism_pkg::A_FIX: begin
                if (r_is_mod) n_res = r_neg_r ? (32'd0 - r_rem[31:0]) : r_rem[31:0];
                else          n_res = r_neg_q ? (32'd0 - r_quo) : r_quo;
            end
            default: n_res = r_res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ism_pkg::A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (r_state == ism_pkg::A_IDLE && i_req.start) begin
            r_rem    <= 33'd0;
            r_quo    <= w_abs_a;
            r_dv     <= w_abs_b;
            r_cnt    <= 5'd31;
            r_neg_q  <= i_a[31] ^ i_b[31];
            r_neg_r  <= i_a[31];
            r_is_mod <= (i_req.op == ism_pkg::OP_MOD);
        end else if (r_state == ism_pkg::A_DIV) begin
            r_rem <= w_diff[32] ? w_rem_sh : w_diff;
            r_quo <= {r_quo[30:0], ~w_diff[32]};
            r_cnt <= r_cnt - 5'd1;
        end
    end

    assign o_rsp.done   = (r_state == ism_pkg::A_DONE);
    assign o_rsp.result = r_res;

endmodule

@@ rtl/core/integer_stack_machine.sv @@
// Sequence: each input transfer steps through RD1, RD2 and EXEC, then ALU when an
// ALU op is needed (div and mod use the 32-step divider), then FIN and OUT.
// A new instruction is taken only after the previous result transfer; the shared
// ALU/divider and the single read port of the stack RAM set this sequence.
// Reset (synchronous, active low): stack empty, all locals read as zero, idle.
`include "integer_stack_machine_assert.svh"

module integer_stack_machine #(
    parameter int STACK_DEPTH = 8,
    parameter int NUM_LOCALS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [5:0]  i_command,
    input  logic [3:0]  i_local_index,
    input  logic [31:0] i_immediate,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_top_value,
    output logic [3:0]  o_stack_depth,
    output logic [2:0]  o_status,
    output logic        o_branch_taken,
    output logic        o_halted
);

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int LAW = (NUM_LOCALS > 1) ? $clog2(NUM_LOCALS) : 1;

    ism_pkg::t_state r_state, n_state;
    logic [SPW-1:0]  r_sp, n_sp;
    logic [5:0]      r_cmd;
    logic [3:0]      r_li;
    logic [31:0]     r_imm, r_a, r_b, r_loc, r_res;
    logic [NUM_LOCALS-1:0] r_lvalid;

    logic [31:0] r_out_top;
    logic [3:0]  r_out_depth;
    ism_pkg::t_status r_out_status;
    logic        r_out_branch, r_out_halted, r_out_valid;

    ism_pkg::t_group  w_grp;
    ism_pkg::t_alu_op w_op;
    ism_pkg::t_alu_req w_req;
    ism_pkg::t_alu_rsp w_rsp;
    logic        w_accept, w_divmod, w_need_alu, w_lin;
    logic [31:0] w_alu_a, w_alu_b, w_srd, w_lrd;
    logic [SPW-1:0] w_sp_m1, w_sp_m2;
    logic [SAW-1:0] w_sraddr;
    logic [7:0]  w_li8, w_ili8;
    logic [LAW-1:0] w_laddr, w_lraddr;

    // Commit outputs of the final step
    ism_pkg::t_status f_status;
    logic        f_branch, f_halted, f_swe, f_lwe;
    logic [SAW-1:0] f_swaddr;
    logic [31:0] f_swdata, f_lwdata, f_top;

    assign w_accept = i_valid && !o_stall;
    assign w_grp    = ism_pkg::decode(r_cmd);
    assign w_op     = ism_pkg::op_of(r_cmd);
    assign w_divmod = (w_op == ism_pkg::OP_DIV) || (w_op == ism_pkg::OP_MOD);
    assign w_sp_m1  = r_sp - SPW'(1);
    assign w_sp_m2  = r_sp - SPW'(2);
    assign w_li8    = 8'(r_li);
    assign w_ili8   = 8'(i_local_index);
    assign w_laddr  = w_li8[LAW-1:0];
    assign w_lraddr = w_ili8[LAW-1:0];
    assign w_lin    = (32'(r_li) < NUM_LOCALS);

    // Stack read address: top first, then the entry below it
    assign w_sraddr = (r_state == ism_pkg::S_RD1) ? w_sp_m2[SAW-1:0] : w_sp_m1[SAW-1:0];

    // ALU operand selection
    always_comb begin
        w_alu_a = r_a;
        w_alu_b = r_loc;
        case (w_grp)
            ism_pkg::G_STACK_OP: begin
                w_alu_a = r_b;
                w_alu_b = r_a;
            end
            ism_pkg::G_IMM_OP: w_alu_b = r_imm;
            default:           w_alu_b = r_loc;
        endcase
    end

    always_comb begin
        case (w_grp)
            ism_pkg::G_STACK_OP: w_need_alu = (r_sp >= SPW'(2)) &&
                                              !(w_divmod && w_alu_b == 32'd0);
            ism_pkg::G_IMM_OP,
            ism_pkg::G_LOCAL_OP: w_need_alu = (r_sp != '0) &&
                                              !(w_divmod && w_alu_b == 32'd0);
            default:             w_need_alu = 1'b0;
        endcase
    end

    assign w_req.start = (r_state == ism_pkg::S_EXEC) && w_need_alu;
    assign w_req.op    = w_op;

    ism_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_alu_a),
        .i_b     (w_alu_b),
        .o_rsp   (w_rsp)
    );

    ism_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (f_swe),
        .i_waddr (f_swaddr),
        .i_wdata (f_swdata),
        .i_raddr (w_sraddr),
        .o_rdata (w_srd)
    );

    ism_ram #(.WIDTH(32), .DEPTH(NUM_LOCALS)) u_local_ram (
        .i_clk   (i_clk),
        .i_we    (f_lwe),
        .i_waddr (w_laddr),
        .i_wdata (f_lwdata),
        .i_raddr (w_lraddr),
        .o_rdata (w_lrd)
    );

    // Final step: status, stack and local writes, new top
    always_comb begin
        f_status = ism_pkg::ST_OK;
        f_branch = 1'b0;
        f_halted = 1'b0;
        f_swe    = 1'b0;
        f_lwe    = 1'b0;
        f_swaddr = r_sp[SAW-1:0];
        f_swdata = r_res;
        f_lwdata = r_a;
        n_sp     = r_sp;
        f_top    = (r_sp != '0) ? r_a : 32'd0;
        case (w_grp)
            ism_pkg::G_HALT: begin
                n_sp     = '0;
                f_top    = 32'd0;
                f_halted = 1'b1;
            end
            ism_pkg::G_IF, ism_pkg::G_POP: begin
                if (r_sp == '0) begin
                    f_status = ism_pkg::ST_UNDER;
                end else begin
                    f_branch = (w_grp == ism_pkg::G_IF) && (r_a != 32'd0);
                    f_lwe    = (w_grp == ism_pkg::G_POP);
                    n_sp     = w_sp_m1;
                    f_top    = (r_sp >= SPW'(2)) ? r_b : 32'd0;
                end
            end
            ism_pkg::G_PUSH_IMM, ism_pkg::G_PUSH_LOCAL,
            ism_pkg::G_PUSH_INC, ism_pkg::G_PUSH_DEC: begin
                if (r_sp == SPW'(STACK_DEPTH)) begin
                    f_status = ism_pkg::ST_OVER;
                end else begin
                    f_swe    = 1'b1;
                    f_swdata = (w_grp == ism_pkg::G_PUSH_IMM) ? r_imm : r_loc;
                    f_top    = f_swdata;
                    n_sp     = r_sp + SPW'(1);
                    f_lwe    = (w_grp == ism_pkg::G_PUSH_INC) ||
                               (w_grp == ism_pkg::G_PUSH_DEC);
                    f_lwdata = (w_grp == ism_pkg::G_PUSH_INC) ? r_loc + 32'd1
                                                              : r_loc - 32'd1;
                end
            end
            ism_pkg::G_INC: begin
                f_lwe    = 1'b1;
                f_lwdata = r_loc + 32'd1;
            end
            ism_pkg::G_DEC: begin
                f_lwe    = 1'b1;
                f_lwdata = r_loc - 32'd1;
            end
            ism_pkg::G_STACK_OP, ism_pkg::G_IMM_OP, ism_pkg::G_LOCAL_OP: begin
                if ((w_grp == ism_pkg::G_STACK_OP) ? (r_sp < SPW'(2)) : (r_sp == '0)) begin
                    f_status = ism_pkg::ST_UNDER;
                end else if (w_divmod && w_alu_b == 32'd0) begin
                    f_status = (w_op == ism_pkg::OP_DIV) ? ism_pkg::ST_DIV0
                                                         : ism_pkg::ST_MOD0;
                end else if (w_grp == ism_pkg::G_STACK_OP) begin
                    f_swe    = 1'b1;
                    f_swaddr = w_sp_m2[SAW-1:0];
                    n_sp     = w_sp_m1;
                    f_top    = r_res;
                end else begin
                    f_swe    = 1'b1;
                    f_swaddr = w_sp_m1[SAW-1:0];
                    f_top    = r_res;
                end
            end
            default: f_status = ism_pkg::ST_OK;
        endcase
        if (r_state != ism_pkg::S_FIN) begin
            f_swe = 1'b0;
            f_lwe = 1'b0;
        end
        if (!w_lin) f_lwe = 1'b0;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ism_pkg::S_IDLE: if (w_accept) n_state = ism_pkg::S_RD1;
            ism_pkg::S_RD1:  n_state = ism_pkg::S_RD2;
            ism_pkg::S_RD2:  n_state = ism_pkg::S_EXEC;
            ism_pkg::S_EXEC: n_state = w_need_alu ? ism_pkg::S_ALU : ism_pkg::S_FIN;
            ism_pkg::S_ALU:  if (w_rsp.done) n_state = ism_pkg::S_FIN;
            ism_pkg::S_FIN:  n_state = ism_pkg::S_OUT;
            ism_pkg::S_OUT:  if (!i_stall) n_state = ism_pkg::S_IDLE;
            default:         n_state = ism_pkg::S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_stall = (r_state != ism_pkg::S_IDLE);
        o_valid = r_out_valid;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ism_pkg::S_IDLE;
            r_sp        <= '0;
            r_lvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (n_state == ism_pkg::S_OUT);
            if (r_state == ism_pkg::S_FIN) begin
                r_sp <= n_sp;
                if (f_lwe) r_lvalid[w_laddr] <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_command;
            r_li  <= i_local_index;
            r_imm <= i_immediate;
        end
        if (r_state == ism_pkg::S_RD1) begin
            r_a   <= w_srd;
            r_loc <= (w_lin && r_lvalid[w_laddr]) ? w_lrd : 32'd0;
        end
        if (r_state == ism_pkg::S_RD2) r_b <= w_srd;
        if (r_state == ism_pkg::S_ALU && w_rsp.done) r_res <= w_rsp.result;
        if (r_state == ism_pkg::S_FIN) begin
            r_out_top    <= f_top;
            r_out_depth  <= 4'(n_sp);
            r_out_status <= f_status;
            r_out_branch <= f_branch;
            r_out_halted <= f_halted;
        end
    end

    assign o_top_value    = r_out_top;
    assign o_stack_depth  = r_out_depth;
    assign o_status       = r_out_status;
    assign o_branch_taken = r_out_branch;
    assign o_halted       = r_out_halted;

    `ISM_ASSERT_NEXT(a_accept_starts_read, w_accept, r_state == ism_pkg::S_RD1)
    `ISM_ASSERT_NOW(a_sp_bounded, 1'b1, r_sp <= SPW'(STACK_DEPTH))
    `ISM_ASSERT_NOW(a_halt_empties, o_valid && o_halted,
                    o_stack_depth == 4'd0 && o_top_value == 32'd0)
    `ISM_ASSERT_NOW(a_error_no_branch, o_valid && o_status != ism_pkg::ST_OK, !o_branch_taken)

endmodule
